FILE: sv/cau_pkg.sv
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } cau_action_t;

    // per-item status that rides along the divider stages
    typedef struct packed {
        logic is_div;
        logic dz;
        logic ovf_re;
        logic ovf_im;
        logic neg_re;
        logic neg_im;
    } cau_flags_t;

endpackage

FILE: sv/complex_arithmetic_unit.sv
// Complex fixed-point ALU: add, subtract, multiply or divide two complex operands in signed
// fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits), one result per transaction. Products
// are kept at full width, multiply and divide round to nearest with ties away from zero, and
// results saturate with the overflow flag set. A divide by zero magnitude returns zero with
// divide_by_zero set. The unit accepts one transaction per clock unless the output stalls;
// every operation runs through the same pipeline, whose depth is set by the restoring divider
// resolving one quotient bit per stage. Output backpressure stalls the whole pipeline in place.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // a_real, a_imag, b_real, b_imag
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // res_real, res_imag
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // divide_by_zero, overflow
    output logic [1:0] m_axis_tuser
);

    localparam int DW    = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int PW    = 2*DW+1;
    localparam int NW    = PW+F+2;
    localparam int DVW   = PW+1;
    localparam int QW    = DW+1;
    localparam int TW    = NW-QW;
    localparam int CW    = (TW > DVW) ? TW : DVW;
    localparam int OUT_W = ((2*DW+7)/8)*8;
    localparam logic [PW:0] HALF = (PW+1)'(F > 0 ? 1 : 0) << (F > 0 ? F-1 : 0);
    localparam logic [PW-1:0] POS_LIM = (PW'(1) << (DW-1)) - PW'(1);
    localparam logic [PW-1:0] NEG_LIM = PW'(1) << (DW-1);

    // returns {overflow, saturated two's complement value}
    function automatic logic [DW:0] sat(input logic neg, input logic [PW-1:0] m);
        logic [PW-1:0] lim;
        logic [DW-1:0] v;
        logic o;
        lim = neg ? NEG_LIM : POS_LIM;
        o = m > lim;
        v = o ? lim[DW-1:0] : m[DW-1:0];
        v = neg ? -v : v;
        return {o, v};
    endfunction

    logic adv;
    logic vld_out_reg;

    assign adv = !vld_out_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 1: products and add/sub sums
    logic signed [DW-1:0] ar, ai, br, bi;
    cau_action_t act_in;
    logic signed [2*DW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbb_reg, pcc_reg;
    logic signed [DW:0] sa_re_reg, sa_im_reg;
    logic signed [DW:0] sa_re_next, sa_im_next;
    cau_action_t act1_reg;
    logic dz1_reg;
    logic vld1_reg;

    assign ar = s_axis_tdata[DW-1:0];
    assign ai = s_axis_tdata[2*DW-1:DW];
    assign br = s_axis_tdata[3*DW-1:2*DW];
    assign bi = s_axis_tdata[4*DW-1:3*DW];
    assign act_in = cau_action_t'(s_axis_tuser);

    always_comb
    begin
        if (act_in == ACT_SUB)
        begin
            sa_re_next = (DW+1)'(ar) - (DW+1)'(br);
            sa_im_next = (DW+1)'(ai) - (DW+1)'(bi);
        end
        else
        begin
            sa_re_next = (DW+1)'(ar) + (DW+1)'(br);
            sa_im_next = (DW+1)'(ai) + (DW+1)'(bi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prr_reg   <= (2*DW)'(ar) * (2*DW)'(br);
            pii_reg   <= (2*DW)'(ai) * (2*DW)'(bi);
            pri_reg   <= (2*DW)'(ar) * (2*DW)'(bi);
            pir_reg   <= (2*DW)'(ai) * (2*DW)'(br);
            pbb_reg   <= (2*DW)'(br) * (2*DW)'(br);
            pcc_reg   <= (2*DW)'(bi) * (2*DW)'(bi);
            sa_re_reg <= sa_re_next;
            sa_im_reg <= sa_im_next;
            act1_reg  <= act_in;
            dz1_reg   <= (act_in == ACT_DIV) && (br == '0) && (bi == '0);
        end
    end

    // stage 2: product sums and squared divisor magnitude
    logic signed [PW-1:0] s_re_reg, s_im_reg, s_re_next, s_im_next;
    logic [2*DW-1:0] d2s_reg;
    cau_action_t act2_reg;
    logic dz2_reg;
    logic vld2_reg;

    always_comb
    begin
        case (act1_reg)
            ACT_MUL:
            begin
                s_re_next = PW'(prr_reg) - PW'(pii_reg);
                s_im_next = PW'(pri_reg) + PW'(pir_reg);
            end
            ACT_DIV:
            begin
                s_re_next = PW'(prr_reg) + PW'(pii_reg);
                s_im_next = PW'(pir_reg) - PW'(pri_reg);
            end
            default:
            begin
                s_re_next = PW'(sa_re_reg);
                s_im_next = PW'(sa_im_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_re_reg <= s_re_next;
            s_im_reg <= s_im_next;
            d2s_reg  <= $unsigned(pbb_reg) + $unsigned(pcc_reg);
            act2_reg <= act1_reg;
            dz2_reg  <= dz1_reg;
        end
    end

    // stage 3: magnitudes, rounding, saturation of non-divide results, divide numerators
    logic neg_re, neg_im;
    logic [PW-1:0] m_re, m_im;
    logic [PW:0] t_re, t_im;
    logic [PW-1:0] sel_re, sel_im;
    logic [DW:0] sat_re, sat_im;
    logic [NW-1:0] n_re3_reg, n_im3_reg;
    logic [DVW-1:0] d3_reg;
    logic [DW-1:0] r3_re_reg, r3_im_reg;
    cau_flags_t f3_reg;
    logic vld3_reg;

    assign neg_re = s_re_reg[PW-1];
    assign neg_im = s_im_reg[PW-1];
    assign m_re   = neg_re ? PW'(-s_re_reg) : PW'(s_re_reg);
    assign m_im   = neg_im ? PW'(-s_im_reg) : PW'(s_im_reg);
    assign t_re   = ((PW+1)'(m_re) + HALF) >> F;
    assign t_im   = ((PW+1)'(m_im) + HALF) >> F;
    assign sel_re = (act2_reg == ACT_MUL) ? t_re[PW-1:0] : m_re;
    assign sel_im = (act2_reg == ACT_MUL) ? t_im[PW-1:0] : m_im;
    assign sat_re = sat(neg_re, sel_re);
    assign sat_im = sat(neg_im, sel_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // rounded quotient = floor((2*m*2^F + D) / (2*D))
            n_re3_reg     <= (NW'(m_re) << (F+1)) + NW'(d2s_reg);
            n_im3_reg     <= (NW'(m_im) << (F+1)) + NW'(d2s_reg);
            d3_reg        <= DVW'(d2s_reg) << 1;
            r3_re_reg     <= sat_re[DW-1:0];
            r3_im_reg     <= sat_im[DW-1:0];
            f3_reg.is_div <= (act2_reg == ACT_DIV);
            f3_reg.dz     <= dz2_reg;
            f3_reg.ovf_re <= sat_re[DW];
            f3_reg.ovf_im <= sat_im[DW];
            f3_reg.neg_re <= neg_re;
            f3_reg.neg_im <= neg_im;
        end
    end

    // stage 4: quotient range check and divider setup
    logic [CW-1:0] top_re, top_im, dcmp;
    logic pov_re, pov_im;
    cau_flags_t f0_next;

    logic [DVW-1:0] r_re_reg [0:QW];
    logic [DVW-1:0] r_im_reg [0:QW];
    logic [QW-1:0] q_re_reg [0:QW];
    logic [QW-1:0] q_im_reg [0:QW];
    logic [QW-1:0] n_re_reg [0:QW];
    logic [QW-1:0] n_im_reg [0:QW];
    logic [DVW-1:0] d_reg [0:QW];
    logic [DW-1:0] pr_re_reg [0:QW];
    logic [DW-1:0] pr_im_reg [0:QW];
    cau_flags_t f_reg [0:QW];
    logic vld_reg [0:QW];

    assign top_re = CW'(n_re3_reg >> QW);
    assign top_im = CW'(n_im3_reg >> QW);
    assign dcmp   = CW'(d3_reg);
    assign pov_re = top_re >= dcmp;
    assign pov_im = top_im >= dcmp;

    always_comb
    begin
        f0_next = f3_reg;
        if (f3_reg.is_div)
        begin
            f0_next.ovf_re = pov_re;
            f0_next.ovf_im = pov_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_re_reg[0]  <= pov_re ? '0 : top_re[DVW-1:0];
            r_im_reg[0]  <= pov_im ? '0 : top_im[DVW-1:0];
            q_re_reg[0]  <= '0;
            q_im_reg[0]  <= '0;
            n_re_reg[0]  <= n_re3_reg[QW-1:0];
            n_im_reg[0]  <= n_im3_reg[QW-1:0];
            d_reg[0]     <= d3_reg;
            pr_re_reg[0] <= r3_re_reg;
            pr_im_reg[0] <= r3_im_reg;
            f_reg[0]     <= f0_next;
        end
    end

    // restoring divider, one quotient bit per stage for both parts
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [DVW:0] rs_re, rs_im;
        logic ge_re, ge_im;
        logic [DVW-1:0] r_re_next, r_im_next;

        always_comb
        begin
            rs_re = {r_re_reg[k], n_re_reg[k][QW-1]};
            rs_im = {r_im_reg[k], n_im_reg[k][QW-1]};
            ge_re = rs_re >= {1'b0, d_reg[k]};
            ge_im = rs_im >= {1'b0, d_reg[k]};
            r_re_next = ge_re ? DVW'(rs_re - {1'b0, d_reg[k]}) : DVW'(rs_re);
            r_im_next = ge_im ? DVW'(rs_im - {1'b0, d_reg[k]}) : DVW'(rs_im);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_re_reg[k+1]  <= r_re_next;
                r_im_reg[k+1]  <= r_im_next;
                q_re_reg[k+1]  <= {q_re_reg[k][QW-2:0], ge_re};
                q_im_reg[k+1]  <= {q_im_reg[k][QW-2:0], ge_im};
                n_re_reg[k+1]  <= n_re_reg[k] << 1;
                n_im_reg[k+1]  <= n_im_reg[k] << 1;
                d_reg[k+1]     <= d_reg[k];
                pr_re_reg[k+1] <= pr_re_reg[k];
                pr_im_reg[k+1] <= pr_im_reg[k];
                f_reg[k+1]     <= f_reg[k];
            end
        end
    end

    // output register
    cau_flags_t fo;
    logic [PW-1:0] qm_re, qm_im;
    logic [DW:0] qs_re, qs_im;
    logic [DW-1:0] res_re_next, res_im_next;
    logic dz_next, ovf_next;
    logic [DW-1:0] res_re_reg, res_im_reg;
    logic dz_reg, ovf_reg;

    assign fo    = f_reg[QW];
    assign qm_re = fo.ovf_re ? '1 : PW'(q_re_reg[QW]);
    assign qm_im = fo.ovf_im ? '1 : PW'(q_im_reg[QW]);
    assign qs_re = sat(fo.neg_re, qm_re);
    assign qs_im = sat(fo.neg_im, qm_im);

    always_comb
    begin
        if (!fo.is_div)
        begin
            res_re_next = pr_re_reg[QW];
            res_im_next = pr_im_reg[QW];
            dz_next     = 1'b0;
            ovf_next    = fo.ovf_re || fo.ovf_im;
        end
        else if (fo.dz)
        begin
            res_re_next = '0;
            res_im_next = '0;
            dz_next     = 1'b1;
            ovf_next    = 1'b0;
        end
        else
        begin
            res_re_next = qs_re[DW-1:0];
            res_im_next = qs_im[DW-1:0];
            dz_next     = 1'b0;
            ovf_next    = qs_re[DW] || qs_im[DW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_out_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            dz_reg     <= dz_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign m_axis_tvalid = vld_out_reg;
    assign m_axis_tdata  = OUT_W'({res_im_reg, res_re_reg});
    assign m_axis_tuser  = {ovf_reg, dz_reg};

endmodule

FILE: dv/cau_checker.sv
module cau_checker
    import cau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    output int           fail_count,
    output int           pending,
    output int           result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        ovf;
    } cplx_result_t;

    cplx_result_t expected_q[$];

    localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

    // clamp a wide signed value to 32 bits
    function automatic logic [31:0] clamp32(input logic signed [67:0] v, inout logic ovf);
        if (v > SAT_HI)
        begin
            ovf = 1'b1;
            return SAT_HI[31:0];
        end
        if (v < SAT_LO)
        begin
            ovf = 1'b1;
            return SAT_LO[31:0];
        end
        return v[31:0];
    endfunction

    // round-half-away-from-zero of num / den, den > 0
    function automatic logic signed [131:0] div_round(input logic signed [131:0] num,
                                                     input logic signed [131:0] den);
        logic [131:0] m;
        logic [131:0] q;
        m = num < 0 ? -num : num;
        q = (2 * m + den) / (2 * den);
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic cplx_result_t compute_result(input cau_action_t act,
                                                    input logic [127:0] d);
        logic signed [31:0]  ar, ai, br, bi;
        logic signed [131:0] pr, pi, den;
        logic signed [67:0]  vr, vi;
        cplx_result_t r;
        ar = d[31:0];
        ai = d[63:32];
        br = d[95:64];
        bi = d[127:96];
        r = '0;
        vr = 0;
        vi = 0;
        case (act)
            ACT_ADD:
            begin
                vr = 68'(ar) + 68'(br);
                vi = 68'(ai) + 68'(bi);
            end
            ACT_SUB:
            begin
                vr = 68'(ar) - 68'(br);
                vi = 68'(ai) - 68'(bi);
            end
            ACT_MUL:
            begin
                pr = 132'(ar) * 132'(br) - 132'(ai) * 132'(bi);
                pi = 132'(ar) * 132'(bi) + 132'(ai) * 132'(br);
                pr = div_round(pr, 132'sd65536);
                pi = div_round(pi, 132'sd65536);
                vr = pr > 132'(SAT_HI) ? SAT_HI + 1 : (pr < 132'(SAT_LO) ? SAT_LO - 1 : pr[67:0]);
                vi = pi > 132'(SAT_HI) ? SAT_HI + 1 : (pi < 132'(SAT_LO) ? SAT_LO - 1 : pi[67:0]);
            end
            default:
            begin
                if (br == 0 && bi == 0)
                begin
                    r.dz = 1'b1;
                    return r;
                end
                den = 132'(br) * 132'(br) + 132'(bi) * 132'(bi);
                pr = (132'(ar) * 132'(br) + 132'(ai) * 132'(bi)) * 132'sd65536;
                pi = (132'(ai) * 132'(br) - 132'(ar) * 132'(bi)) * 132'sd65536;
                pr = div_round(pr, den);
                pi = div_round(pi, den);
                vr = pr > 132'(SAT_HI) ? SAT_HI + 1 : (pr < 132'(SAT_LO) ? SAT_LO - 1 : pr[67:0]);
                vi = pi > 132'(SAT_HI) ? SAT_HI + 1 : (pi < 132'(SAT_LO) ? SAT_LO - 1 : pi[67:0]);
            end
        endcase
        r.re = clamp32(vr, r.ovf);
        r.im = clamp32(vi, r.ovf);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on result %0d: %s got %h want %h", result_count, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        result_count = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        cplx_result_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_q.push_back(compute_result(cau_action_t'(s_axis_tuser), s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result transaction", m_axis_tdata[31:0], 32'h0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_axis_tdata[31:0] !== want.re)
                    report_mismatch("res_real", m_axis_tdata[31:0], want.re);
                if (m_axis_tdata[63:32] !== want.im)
                    report_mismatch("res_imag", m_axis_tdata[63:32], want.im);
                if (m_axis_tuser[0] !== want.dz)
                    report_mismatch("divide_by_zero", 32'(m_axis_tuser[0]), 32'(want.dz));
                if (m_axis_tuser[1] !== want.ovf)
                    report_mismatch("overflow", 32'(m_axis_tuser[1]), 32'(want.ovf));
            end
            result_count++;
        end
        pending = expected_q.size();
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 200000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = ACT_ADD;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           fail_count, pending, result_count;
    int           cycles = 0;
    int           sent = 0;
    logic         quiet_stretch = 1'b0;

    always #10 clk = ~clk;

    complex_arithmetic_unit uut (.*);

    cau_checker checker_i (.*);

    function automatic int gap_len();
        if (quiet_stretch)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'(int'($urandom_range(0, 6)) - 3) << 16;
            4: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input cau_action_t act, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {bi, br, ai, ar};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    // result-side stalls
    always @(posedge clk)
    begin
        if (quiet_stretch)
            m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 29) == 0)
            m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0)
            m_axis_tready <= ~m_axis_tready;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] extremes [4];
        extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: each operation on extreme operands, divide by zero, real scaling
        for (int k = 0; k < 4; k++)
        begin
            send_item(ACT_ADD, extremes[k], extremes[k], extremes[k], extremes[k]);
            send_item(ACT_SUB, extremes[k], extremes[3 - k], extremes[3 - k], extremes[k]);
            send_item(ACT_MUL, extremes[k], extremes[k], extremes[k], extremes[3 - k]);
            send_item(ACT_DIV, extremes[k], extremes[3 - k], extremes[k], extremes[k]);
        end
        send_item(ACT_DIV, 32'h0001_0000, 32'h0002_0000, '0, '0);
        send_item(ACT_DIV, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
        send_item(ACT_MUL, 32'h0003_0000, 32'hfffe_0000, 32'h0002_8000, '0);
        send_item(ACT_DIV, 32'h0003_0000, 32'hfffe_0000, 32'h0002_0000, '0);
        send_item(ACT_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_8000, '0);
        send_item(ACT_DIV, 32'h0000_0001, '0, 32'h0000_0002, '0);
        send_item(ACT_DIV, 32'h0001_0000, '0, 32'h0000_0001, '0);
        send_item(ACT_MUL, 32'hffff_ffff, 32'h0000_0001, 32'hffff_8000, 32'h0000_8000);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 300 == 150)
                quiet_stretch <= 1'b1;
            if (n % 300 == 200)
                quiet_stretch <= 1'b0;
            send_item(cau_action_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                      $urandom_range(0, 9) == 0 ? 32'h0 : pick_operand(),
                      $urandom_range(0, 3) == 0 ? 32'h0 : pick_operand());
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("sent %0d transactions of all four operations, %0d results compared",
                 sent, result_count);
        $display("operands covered extremes, real scalars, zero divisors and random stalls");
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
sv/cau_pkg.sv
sv/complex_arithmetic_unit.sv
dv/cau_checker.sv
dv/tb_top.sv
